@@ sv/bankers_safety_check_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Banker's algorithm safety check
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_CHECK_MACROS_SVH
`define BANKERS_SAFETY_CHECK_MACROS_SVH

// Same-cycle implication.
`define BSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bankers_safety_check: same-cycle check failed");

// Next-cycle implication.
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bankers_safety_check: next-cycle check failed");

`endif

@@ sv/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, codes and defaults shared by the safety check modules.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Default sizes of the tables.
  localparam int PROCESSES_DEF    = 16;
  localparam int RESOURCES_DEF    = 8;
  localparam int AMOUNT_WIDTH_DEF = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 2'd1;

  // Input function codes.
  localparam logic [1:0] FUNC_LOAD_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_LOAD_MAX   = 2'd1;
  localparam logic [1:0] FUNC_LOAD_AVAIL = 2'd2;
  localparam logic [1:0] FUNC_RUN        = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_SAFE     = 2'd0;
  localparam logic [1:0] ST_DEADLOCK = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  process_index;
    logic [2:0]  resource_index;
    logic [15:0] amount;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] process_id;
    logic [3:0] order_position;
    logic       last;
  } res_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_NEXT,
    S_ADV,
    S_FIT,
    S_ADD,
    S_RESULT,
    S_EMIT_RD,
    S_EMIT_WR
  } bsc_state_e;

endpackage

@@ sv/bsc_table_mem.sv @@
// ----------------------------------------------------------------------------
// bsc_table_mem
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module bsc_table_mem #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bsc_out_buf.sv @@
// ----------------------------------------------------------------------------
// bsc_out_buf
// Output register holding one result word for the downstream handshake.
// ----------------------------------------------------------------------------
module bsc_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bsc_pkg::res_item_t data_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output bsc_pkg::res_item_t data_o
);

  logic               valid_q;
  bsc_pkg::res_item_t data_q;

  // The slot is free when empty or when its word leaves this cycle.
  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/bsc_engine.sv @@
// ----------------------------------------------------------------------------
// bsc_engine
// Load decode, count registers and the sequencer that walks the allocation
// and maximum tables through their read port to build the safe order.
// ----------------------------------------------------------------------------
module bsc_engine #(
  parameter int PROCESSES    = bsc_pkg::PROCESSES_DEF,
  parameter int RESOURCES    = bsc_pkg::RESOURCES_DEF,
  parameter int AMOUNT_WIDTH = bsc_pkg::AMOUNT_WIDTH_DEF,
  localparam int PW     = $clog2(PROCESSES),
  localparam int RW     = (RESOURCES > 1) ? $clog2(RESOURCES) : 1,
  localparam int ADDR_W = PW + RW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bsc_pkg::in_item_t             in_item_i,
  // Configuration writes
  input  logic                          cfg_valid_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Table ports
  output logic                          alloc_we_o,
  output logic                          max_we_o,
  output logic [ADDR_W-1:0]             tbl_waddr_o,
  output logic [AMOUNT_WIDTH-1:0]       tbl_wdata_o,
  output logic [ADDR_W-1:0]             tbl_raddr_o,
  input  logic [AMOUNT_WIDTH-1:0]       alloc_rdata_i,
  input  logic [AMOUNT_WIDTH-1:0]       max_rdata_i,
  // Result words
  output logic                          res_push_o,
  output bsc_pkg::res_item_t            res_o,
  input  logic                          res_free_i
);

  localparam int AW = AMOUNT_WIDTH;

  bsc_pkg::bsc_state_e state_q, state_d;

  logic [4:0]           process_count_q;
  logic [3:0]           resource_count_q;
  logic [4:0]           pc;
  logic [3:0]           rc;

  logic [PW-1:0]        p_q, p_d;
  logic [RW-1:0]        r_q, r_d;
  logic                 iss_q, iss_d;
  logic                 ev_v_q, ev_v_d;
  logic [RW-1:0]        ev_r_q, ev_r_d;
  logic                 ev_fin_q, ev_fin_d;
  logic [PROCESSES-1:0] finished_q, finished_d;
  logic [4:0]           found_q, found_d;
  logic                 progress_q, progress_d;
  logic [4:0]           emit_q, emit_d;
  logic [1:0]           res_status_q, res_status_d;

  logic [AW-1:0]        avail_q [RESOURCES];
  logic [AW-1:0]        work_q  [RESOURCES];
  logic [PW-1:0]        order_mem [PROCESSES];
  logic [PW-1:0]        order_rd_q;

  logic                 accept;
  logic                 ri_ok;
  logic                 pi_ok;
  logic                 p_last;
  logic                 r_last;
  logic                 emit_last;
  logic                 scanning;
  logic                 work_init;
  logic                 work_wr;
  logic                 order_we;
  logic [AW-1:0]        work_rd;
  logic [AW-1:0]        need;
  logic [AW:0]          sum;
  logic [AW-1:0]        work_sum;
  logic                 over;
  logic                 misfit;

  // Counts in use: zero acts as one, large values saturate to the table size.
  always_comb begin
    if (process_count_q == 5'd0) begin
      pc = 5'd1;
    end else if (32'(process_count_q) > PROCESSES) begin
      pc = 5'(PROCESSES);
    end else begin
      pc = process_count_q;
    end
    if (resource_count_q == 4'd0) begin
      rc = 4'd1;
    end else if (32'(resource_count_q) > RESOURCES) begin
      rc = 4'(RESOURCES);
    end else begin
      rc = resource_count_q;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_count_q  <= 5'd1;
      resource_count_q <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bsc_pkg::CFG_PROCESS_COUNT:  process_count_q  <= cfg_data_i;
        bsc_pkg::CFG_RESOURCE_COUNT: resource_count_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Load decode; out-of-range indexes are dropped.
  assign accept      = in_valid_i && in_ready_o;
  assign ri_ok       = 32'(in_item_i.resource_index) < RESOURCES;
  assign pi_ok       = 32'(in_item_i.process_index) < PROCESSES;
  assign tbl_waddr_o = {PW'(in_item_i.process_index), RW'(in_item_i.resource_index)};
  assign tbl_wdata_o = AW'(in_item_i.amount);
  assign alloc_we_o  = accept && (in_item_i.func == bsc_pkg::FUNC_LOAD_ALLOC) && ri_ok && pi_ok;
  assign max_we_o    = accept && (in_item_i.func == bsc_pkg::FUNC_LOAD_MAX) && ri_ok && pi_ok;
  assign tbl_raddr_o = {p_q, r_q};

  // Sweep positions.
  assign p_last    = (32'(p_q) + 1) == 32'(pc);
  assign r_last    = (32'(r_q) + 1) == 32'(rc);
  assign emit_last = (32'(emit_q) + 1) == 32'(pc);
  assign scanning  = (state_q == bsc_pkg::S_CHECK) || (state_q == bsc_pkg::S_FIT) ||
                     (state_q == bsc_pkg::S_ADD);

  // Datapath on the word returned from the tables.
  assign work_rd  = work_q[ev_r_q];
  assign need     = max_rdata_i - alloc_rdata_i;
  assign sum      = {1'b0, work_rd} + {1'b0, alloc_rdata_i};
  assign work_sum = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
  assign over     = alloc_rdata_i > max_rdata_i;
  assign misfit   = need > work_rd;

  // Next state and outputs of the sequencer.
  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    r_d          = r_q;
    iss_d        = iss_q;
    ev_v_d       = 1'b0;
    ev_r_d       = ev_r_q;
    ev_fin_d     = ev_fin_q;
    finished_d   = finished_q;
    found_d      = found_q;
    progress_d   = progress_q;
    emit_d       = emit_q;
    res_status_d = res_status_q;
    work_init    = 1'b0;
    work_wr      = 1'b0;
    order_we     = 1'b0;
    in_ready_o   = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '{status: res_status_q, process_id: 4'd0, order_position: 4'd0,
                     last: 1'b1};

    // Read issue shared by the three table sweeps.
    if (iss_q && scanning) begin
      ev_v_d   = 1'b1;
      ev_r_d   = r_q;
      ev_fin_d = r_last && (p_last || (state_q != bsc_pkg::S_CHECK));
      if (r_last) begin
        r_d = '0;
        if (state_q == bsc_pkg::S_CHECK) begin
          p_d = PW'(p_q + 1'b1);
        end
      end else begin
        r_d = RW'(r_q + 1'b1);
      end
      if (ev_fin_d) begin
        iss_d = 1'b0;
      end
    end

    unique case (state_q)
      bsc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (in_item_i.func == bsc_pkg::FUNC_RUN)) begin
          p_d     = '0;
          r_d     = '0;
          iss_d   = 1'b1;
          state_d = bsc_pkg::S_CHECK;
        end
      end
      // Every entry in use must have allocation within maximum.
      bsc_pkg::S_CHECK: begin
        if (ev_v_q) begin
          if (over) begin
            ev_v_d       = 1'b0;
            iss_d        = 1'b0;
            res_status_d = bsc_pkg::ST_INVALID;
            state_d      = bsc_pkg::S_RESULT;
          end else if (ev_fin_q) begin
            work_init  = 1'b1;
            finished_d = '0;
            found_d    = 5'd0;
            progress_d = 1'b0;
            p_d        = '0;
            state_d    = bsc_pkg::S_NEXT;
          end
        end
      end
      bsc_pkg::S_NEXT: begin
        if (finished_q[p_q]) begin
          state_d = bsc_pkg::S_ADV;
        end else begin
          r_d     = '0;
          iss_d   = 1'b1;
          state_d = bsc_pkg::S_FIT;
        end
      end
      // Move to the next process, or close the pass.
      bsc_pkg::S_ADV: begin
        if (!p_last) begin
          p_d     = PW'(p_q + 1'b1);
          state_d = bsc_pkg::S_NEXT;
        end else if (found_q == pc) begin
          emit_d  = 5'd0;
          state_d = bsc_pkg::S_EMIT_RD;
        end else if (progress_q) begin
          p_d        = '0;
          progress_d = 1'b0;
          state_d    = bsc_pkg::S_NEXT;
        end else begin
          res_status_d = bsc_pkg::ST_DEADLOCK;
          state_d      = bsc_pkg::S_RESULT;
        end
      end
      // Need must fit in the work vector for every resource in use.
      bsc_pkg::S_FIT: begin
        if (ev_v_q) begin
          if (misfit) begin
            ev_v_d  = 1'b0;
            iss_d   = 1'b0;
            state_d = bsc_pkg::S_ADV;
          end else if (ev_fin_q) begin
            r_d     = '0;
            iss_d   = 1'b1;
            state_d = bsc_pkg::S_ADD;
          end
        end
      end
      // Release the allocation back into the work vector.
      bsc_pkg::S_ADD: begin
        if (ev_v_q) begin
          work_wr = 1'b1;
          if (ev_fin_q) begin
            finished_d[p_q] = 1'b1;
            order_we        = 1'b1;
            found_d         = 5'(found_q + 5'd1);
            progress_d      = 1'b1;
            state_d         = bsc_pkg::S_ADV;
          end
        end
      end
      bsc_pkg::S_RESULT: begin
        if (res_free_i) begin
          res_push_o = 1'b1;
          state_d    = bsc_pkg::S_IDLE;
        end
      end
      bsc_pkg::S_EMIT_RD: begin
        state_d = bsc_pkg::S_EMIT_WR;
      end
      bsc_pkg::S_EMIT_WR: begin
        res_o = '{status: bsc_pkg::ST_SAFE, process_id: 4'(order_rd_q),
                  order_position: emit_q[3:0], last: emit_last};
        if (res_free_i) begin
          res_push_o = 1'b1;
          if (emit_last) begin
            state_d = bsc_pkg::S_IDLE;
          end else begin
            emit_d  = 5'(emit_q + 5'd1);
            state_d = bsc_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = bsc_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bsc_pkg::S_IDLE;
      p_q          <= '0;
      r_q          <= '0;
      iss_q        <= 1'b0;
      ev_v_q       <= 1'b0;
      finished_q   <= '0;
      found_q      <= 5'd0;
      progress_q   <= 1'b0;
      emit_q       <= 5'd0;
      res_status_q <= bsc_pkg::ST_SAFE;
    end else begin
      state_q      <= state_d;
      p_q          <= p_d;
      r_q          <= r_d;
      iss_q        <= iss_d;
      ev_v_q       <= ev_v_d;
      finished_q   <= finished_d;
      found_q      <= found_d;
      progress_q   <= progress_d;
      emit_q       <= emit_d;
      res_status_q <= res_status_d;
    end
  end

  // Evaluation stage tags travel with the read.
  always_ff @(posedge clk_i) begin
    ev_r_q   <= ev_r_d;
    ev_fin_q <= ev_fin_d;
  end

  // Available and work vectors.
  always_ff @(posedge clk_i) begin
    if (accept && (in_item_i.func == bsc_pkg::FUNC_LOAD_AVAIL) && ri_ok) begin
      avail_q[RW'(in_item_i.resource_index)] <= AW'(in_item_i.amount);
    end
    if (work_init) begin
      for (int i = 0; i < RESOURCES; i++) begin
        work_q[i] <= avail_q[i];
      end
    end else if (work_wr) begin
      work_q[ev_r_q] <= work_sum;
    end
  end

  // Safe order memory: written as processes finish, read back for output.
  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[PW'(found_q)] <= p_q;
    end
    order_rd_q <= order_mem[PW'(emit_q)];
  end

endmodule

@@ sv/bankers_safety_check.sv @@
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm safety check over allocation and maximum tables.
// ----------------------------------------------------------------------------
// Usage:
// Input words carry func, process_index, resource_index and amount. Load words
// (allocation, maximum, available) are taken one per cycle while the sequencer
// is idle and write their entry at the accept edge; they give no result. A run
// word starts the check and holds in_ready_o low until the run has handed its
// last result to the output register. Configuration writes (process and
// resource counts) are always ready and belong between runs.
// A run with P processes and R resources in use first makes the bounds check,
// streaming one table read per cycle through the memory port. Each process
// visit reads its row for the fit test and, if the need fits, again for the
// release; a run makes at most P passes over the processes. A safe order then
// streams out one result at a time, each read from the order memory first.
// A failed check gives a single result marked last.
// Results sit in a one-word output register; a stalled receiver holds the
// sequencer, and the next input word may be taken while the last result still
// waits. Reset clears the control state and sets both counts to one; the
// tables need no clearing pass and hold what was last written.
// ----------------------------------------------------------------------------
`include "bankers_safety_check_macros.svh"

module bankers_safety_check #(
  parameter int PROCESSES    = bsc_pkg::PROCESSES_DEF,
  parameter int RESOURCES    = bsc_pkg::RESOURCES_DEF,
  parameter int AMOUNT_WIDTH = bsc_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bsc_pkg::in_item_t              in_item_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bsc_pkg::res_item_t             out_item_o,
  // Configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW     = $clog2(PROCESSES);
  localparam int RW     = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int ADDR_W = PW + RW;

  logic                    alloc_we;
  logic                    max_we;
  logic [ADDR_W-1:0]       tbl_waddr;
  logic [AMOUNT_WIDTH-1:0] tbl_wdata;
  logic [ADDR_W-1:0]       tbl_raddr;
  logic [AMOUNT_WIDTH-1:0] alloc_rdata;
  logic [AMOUNT_WIDTH-1:0] max_rdata;
  logic                    res_push;
  bsc_pkg::res_item_t      res;
  logic                    res_free;

  // Count registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  bsc_engine #(
    .PROCESSES    (PROCESSES),
    .RESOURCES    (RESOURCES),
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .alloc_we_o    (alloc_we),
    .max_we_o      (max_we),
    .tbl_waddr_o   (tbl_waddr),
    .tbl_wdata_o   (tbl_wdata),
    .tbl_raddr_o   (tbl_raddr),
    .alloc_rdata_i (alloc_rdata),
    .max_rdata_i   (max_rdata),
    .res_push_o    (res_push),
    .res_o         (res),
    .res_free_i    (res_free)
  );

  // Allocation table; written only while the sequencer is idle.
  bsc_table_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (AMOUNT_WIDTH)
  ) u_alloc_mem (
    .clk_i   (clk_i),
    .we_i    (alloc_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (alloc_rdata)
  );

  // Maximum table, read at the same address as the allocation table.
  bsc_table_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (AMOUNT_WIDTH)
  ) u_max_mem (
    .clk_i   (clk_i),
    .we_i    (max_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (max_rdata)
  );

  // Output register.
  bsc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .free_o  (res_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_item_o)
  );

  // A run word closes the input until its results are out.
  `BSC_ASSERT_NEXT(a_run_blocks_input, in_valid_i && in_ready_o && (in_item_i.func == bsc_pkg::FUNC_RUN), !in_ready_o)

  // Deadlock and invalid results stand alone and end the run.
  `BSC_ASSERT_IMP(a_fail_is_last, out_valid_o && (out_item_o.status != bsc_pkg::ST_SAFE), out_item_o.last)

  // Deadlock and invalid results carry no process or position.
  `BSC_ASSERT_IMP(a_fail_zero_fields, out_valid_o && (out_item_o.status != bsc_pkg::ST_SAFE), (out_item_o.process_id == 4'd0) && (out_item_o.order_position == 4'd0))

  // Only the three defined status codes are produced.
  `BSC_ASSERT_IMP(a_status_code, out_valid_o, (out_item_o.status == bsc_pkg::ST_SAFE) || (out_item_o.status == bsc_pkg::ST_DEADLOCK) || (out_item_o.status == bsc_pkg::ST_INVALID))

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for the Banker's algorithm safety check
// Drives load and run words through the valid/ready input channel, writes the
// count registers between phases, predicts every result word from a shadow
// copy of the tables, and checks each result word in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bsc_pkg::*;

  localparam int NPROC         = PROCESSES_DEF;
  localparam int NRES          = RESOURCES_DEF;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_STRETCH  = 300;
  // Register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd2;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  res_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow tables and count registers used for prediction.
  bit [15:0] alloc_units [NPROC][NRES];
  bit [15:0] max_units   [NPROC][NRES];
  bit [15:0] free_units  [NRES];
  bit        alloc_set   [NPROC][NRES];
  bit        max_set     [NPROC][NRES];
  bit        free_set    [NRES];
  bit [4:0]  proc_count_reg;
  bit [3:0]  res_count_reg;

  res_item_t pending_results[$];
  int        mismatch_count;
  int        words_sent;
  int        cycle_count;
  int        hold_cycles;
  bit        no_idle;

  bankers_safety_check DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock.
  always #6 clk = ~clk;

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // A count of zero acts as one, and a count above the table size saturates.
  function automatic int effective_count(input int v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int procs_in_use();
    return effective_count(proc_count_reg, NPROC);
  endfunction

  function automatic int res_in_use();
    return effective_count(res_count_reg, NRES);
  endfunction

  function automatic void push_result(input logic [1:0] st, input int pid, input int pos,
                                      input bit fin);
    res_item_t r;
    r.status         = st;
    r.process_id     = pid[3:0];
    r.order_position = pos[3:0];
    r.last           = fin;
    pending_results.push_back(r);
  endfunction

  // Safety check over the shadow tables: bounds check, then repeated
  // ascending passes that release each process whose need fits.
  function automatic void predict_safety_run();
    int        pc;
    int        rc;
    int        found;
    int        order [NPROC];
    bit [15:0] work [NRES];
    bit [NPROC-1:0] finished;
    bit        progress;
    bit        fits;
    bit [16:0] sum;
    pc = procs_in_use();
    rc = res_in_use();
    for (int p = 0; p < pc; p++) begin
      for (int r = 0; r < rc; r++) begin
        if (alloc_units[p][r] > max_units[p][r]) begin
          push_result(ST_INVALID, 0, 0, 1'b1);
          return;
        end
      end
    end
    work = free_units;
    finished = '0;
    found = 0;
    do begin
      progress = 1'b0;
      for (int p = 0; p < pc; p++) begin
        if (finished[p]) continue;
        fits = 1'b1;
        for (int r = 0; r < rc; r++) begin
          if (max_units[p][r] - alloc_units[p][r] > work[r]) fits = 1'b0;
        end
        if (!fits) continue;
        for (int r = 0; r < rc; r++) begin
          sum = {1'b0, work[r]} + {1'b0, alloc_units[p][r]};
          work[r] = sum[16] ? 16'hFFFF : sum[15:0];
        end
        finished[p] = 1'b1;
        order[found] = p;
        found++;
        progress = 1'b1;
      end
    end while (progress);
    if (found != pc) begin
      push_result(ST_DEADLOCK, 0, 0, 1'b1);
      return;
    end
    for (int k = 0; k < pc; k++) push_result(ST_SAFE, order[k], k, k == pc - 1);
  endfunction

  // Update the shadow state for one accepted input word.
  function automatic void apply_word(input in_item_t w);
    case (w.func)
      FUNC_LOAD_ALLOC: begin
        alloc_units[w.process_index][w.resource_index] = w.amount;
        alloc_set[w.process_index][w.resource_index]   = 1'b1;
      end
      FUNC_LOAD_MAX: begin
        max_units[w.process_index][w.resource_index] = w.amount;
        max_set[w.process_index][w.resource_index]   = 1'b1;
      end
      FUNC_LOAD_AVAIL: begin
        free_units[w.resource_index] = w.amount;
        free_set[w.resource_index]   = 1'b1;
      end
      default: predict_safety_run();
    endcase
  endfunction

  // Mostly small amounts so that needs and releases interact, with the full
  // range and the edges mixed in.
  function automatic bit [15:0] rand_amount();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(0, 15);
    if (sel < 85) return $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Compare one result word with the oldest expectation.
  function automatic void check_result(input res_item_t got);
    res_item_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected result word: status %0d id %0d pos %0d last %0d",
                 got.status, got.process_id, got.order_position, got.last);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status || got.process_id !== want.process_id ||
        got.order_position !== want.order_position || got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("result mismatch: expected status %0d id %0d pos %0d last %0d, got %0d %0d %0d %0d",
                 want.status, want.process_id, want.order_position, want.last,
                 got.status, got.process_id, got.order_position, got.last);
    end
  endfunction

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : result_sink
    int stall;
    bit taken;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(posedge clk);
        if (out_valid && out_ready) begin
          taken = 1'b1;
          check_result(out_item);
        end else if (hold_cycles > 0) begin
          out_ready <= 1'b0;
          repeat (hold_cycles) @(posedge clk);
          hold_cycles = 0;
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Send one input word after a random gap (none when no_idle is set) and wait for it to be taken.
  task automatic send_word(input in_item_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    apply_word(w);
    words_sent++;
  endtask

  task automatic load_entry(input logic [1:0] func, input int p, input int r,
                            input logic [15:0] amt);
    in_item_t w;
    w.func           = func;
    w.process_index  = p[3:0];
    w.resource_index = r[2:0];
    w.amount         = amt;
    send_word(w);
  endtask

  // Run word; the index and amount fields carry random content.
  task automatic start_run();
    load_entry(FUNC_RUN, $urandom_range(0, 15), $urandom_range(0, 7), $urandom);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == CFG_PROCESS_COUNT) proc_count_reg = data;
    else if (idx == CFG_RESOURCE_COUNT) res_count_reg = data[3:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let every expected word arrive and the block go idle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every entry that the next run will read and that was never written.
  task automatic fill_unwritten();
    bit [15:0] m;
    bit [16:0] raised;
    for (int r = 0; r < NRES; r++)
      if (!free_set[r]) load_entry(FUNC_LOAD_AVAIL, 0, r, $urandom_range(0, 15));
    for (int p = 0; p < procs_in_use(); p++) begin
      for (int r = 0; r < res_in_use(); r++) begin
        if (!max_set[p][r] && !alloc_set[p][r]) begin
          m = $urandom_range(0, 7);
          load_entry(FUNC_LOAD_MAX, p, r, m);
          load_entry(FUNC_LOAD_ALLOC, p, r, $urandom_range(0, m));
        end else if (!max_set[p][r]) begin
          raised = {1'b0, alloc_units[p][r]} + $urandom_range(0, 3);
          load_entry(FUNC_LOAD_MAX, p, r, raised[16] ? 16'hFFFF : raised[15:0]);
        end else if (!alloc_set[p][r]) begin
          load_entry(FUNC_LOAD_ALLOC, p, r, $urandom_range(0, max_units[p][r]));
        end
      end
    end
  endtask

  // Lower any allocation above its maximum within the entries in use.
  task automatic repair_violations();
    for (int p = 0; p < procs_in_use(); p++)
      for (int r = 0; r < res_in_use(); r++)
        if (alloc_set[p][r] && max_set[p][r] && alloc_units[p][r] > max_units[p][r])
          load_entry(FUNC_LOAD_ALLOC, p, r, max_units[p][r]);
  endtask

  // A few table updates with random content, then a run.
  task automatic run_scenario();
    int        updates;
    int        sel;
    int        p;
    int        r;
    bit [15:0] m;
    in_item_t  w;
    updates = $urandom_range(1, 6);
    repeat (updates) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        p = $urandom_range(0, procs_in_use() - 1);
        r = $urandom_range(0, res_in_use() - 1);
        m = rand_amount();
        load_entry(FUNC_LOAD_MAX, p, r, m);
        load_entry(FUNC_LOAD_ALLOC, p, r, $urandom_range(0, m));
      end else if (sel < 80) begin
        load_entry(FUNC_LOAD_AVAIL, $urandom_range(0, 15), $urandom_range(0, 7), rand_amount());
      end else begin
        // Unconstrained load, possibly leaving an allocation above its maximum.
        w = in_item_t'($urandom);
        w.func = $urandom_range(0, 2);
        send_word(w);
      end
    end
    if ($urandom_range(0, 3) != 0) repair_violations();
    fill_unwritten();
    start_run();
  endtask

  // After reset both counts are one: a single process that fits.
  task automatic test_reset_counts();
    load_entry(FUNC_LOAD_AVAIL, 0, 0, 16'd2);
    load_entry(FUNC_LOAD_AVAIL, 15, 1, 16'hFFFF);
    load_entry(FUNC_LOAD_AVAIL, 0, 2, 16'h5555);
    load_entry(FUNC_LOAD_AVAIL, 0, 3, 16'hAAAA);
    load_entry(FUNC_LOAD_AVAIL, 0, 4, 16'h0000);
    for (int r = 5; r < NRES; r++) load_entry(FUNC_LOAD_AVAIL, 0, r, $urandom_range(0, 15));
    load_entry(FUNC_LOAD_MAX, 15, 7, 16'hFFFF);
    load_entry(FUNC_LOAD_ALLOC, 15, 7, 16'h0000);
    load_entry(FUNC_LOAD_ALLOC, 0, 0, 16'd3);
    load_entry(FUNC_LOAD_MAX, 0, 0, 16'd5);
    start_run();
  endtask

  // Zero counts act as one; a write to an undecoded index changes nothing.
  task automatic test_count_clamping();
    wait_quiet();
    write_register(CFG_PROCESS_COUNT, 5'd0);
    write_register(CFG_RESOURCE_COUNT, 5'd0);
    write_register(CFG_SPARE_IDX, 5'd31);
    start_run();
  endtask

  // Allocation above maximum gives a single invalid word.
  task automatic test_invalid_tables();
    wait_quiet();
    write_register(CFG_PROCESS_COUNT, 5'd2);
    write_register(CFG_RESOURCE_COUNT, 5'd1);
    load_entry(FUNC_LOAD_MAX, 1, 0, 16'hFFFE);
    load_entry(FUNC_LOAD_ALLOC, 1, 0, 16'hFFFF);
    start_run();
  endtask

  // Nothing fits the empty work vector.
  task automatic test_deadlock();
    load_entry(FUNC_LOAD_ALLOC, 1, 0, 16'h0000);
    load_entry(FUNC_LOAD_MAX, 1, 0, 16'hFFFF);
    load_entry(FUNC_LOAD_AVAIL, 0, 0, 16'h0000);
    start_run();
  endtask

  // Process 1 only fits if the release of process 0 saturates instead of
  // wrapping around.
  task automatic test_saturating_release();
    load_entry(FUNC_LOAD_AVAIL, 0, 0, 16'hFFFF);
    start_run();
  endtask

  task automatic test_random_phase(input logic [4:0] pc_data, input logic [4:0] rc_data,
                                   input int budget);
    int first;
    wait_quiet();
    write_register(CFG_PROCESS_COUNT, pc_data);
    write_register(CFG_RESOURCE_COUNT, rc_data);
    first = words_sent;
    while (words_sent - first < budget) run_scenario();
  endtask

  // The receiver holds off while a long safe order is produced and the
  // sender keeps offering words, so the block backs up to its input.
  task automatic test_output_backpressure();
    wait_quiet();
    write_register(CFG_PROCESS_COUNT, 5'd16);
    write_register(CFG_RESOURCE_COUNT, 5'd8);
    for (int r = 0; r < NRES; r++) load_entry(FUNC_LOAD_AVAIL, 0, r, 16'hFFFF);
    repair_violations();
    fill_unwritten();
    hold_cycles = HOLD_STRETCH;
    start_run();
    repeat (4) load_entry(FUNC_LOAD_AVAIL, 0, $urandom_range(0, 7), rand_amount());
    start_run();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    proc_count_reg = 5'd1;
    res_count_reg  = 4'd1;
    mismatch_count = 0;
    words_sent     = 0;
    cycle_count    = 0;
    hold_cycles    = 0;
    no_idle        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_counts();
    test_count_clamping();
    test_invalid_tables();
    test_deadlock();
    test_saturating_release();

    test_random_phase(5'd4, 5'd3, 30);
    test_random_phase(5'd16, 5'd1, 30);
    test_random_phase(5'd1, 5'd8, 25);
    no_idle = 1'b1;
    test_random_phase(5'd5, 5'd2, 30);
    no_idle = 1'b0;
    test_random_phase(5'd31, 5'd31, 40);
    test_random_phase($urandom_range(0, 31), $urandom_range(0, 31), 30);
    test_output_backpressure();

    wait_quiet();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ bankers_safety_check.f @@
+incdir+sv
sv/bsc_pkg.sv
sv/bsc_table_mem.sv
sv/bsc_out_buf.sv
sv/bsc_engine.sv
sv/bankers_safety_check.sv
bench/testbench.sv
